@@ rtl/uhr_pkg.sv @@
// Shared types, constants and helpers for the unit hydrograph routing step.
// Used by uhr_mul_unit and unit_hydrograph_routing_step_core.
`timescale 1ns / 1ps

package uhr_pkg;

  // Default number of hydrograph ordinates
  localparam int unsigned MaxTapsDef = 64;

  // Configuration register indexes
  localparam logic [2:0] CFG_TAP_COUNT       = 3'd0;
  localparam logic [2:0] CFG_LATERAL_MODE    = 3'd1;
  localparam logic [2:0] CFG_STEP_LENGTH     = 3'd2;
  localparam logic [2:0] CFG_STEP_OVER_DELAY = 3'd3;
  localparam logic [2:0] CFG_SHORTCUT_MARGIN = 3'd4;

  // Register reset values
  localparam logic [6:0]  TapCountRst      = 7'd1;
  localparam logic [15:0] StepLengthRst    = 16'd256;
  localparam logic [23:0] StepOverDelayRst = 24'd65536;
  localparam logic [15:0] ShortcutMarginRst = 16'd33;

  // Status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_MISSING = 1'b1;

  // Input kinds
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_FLOW = 1'b1;

  // Fraction bits dropped after a product
  typedef enum logic [1:0] {
    SHIFT_8,
    SHIFT_15,
    SHIFT_16
  } shift_sel_e;

  // Request into the shared multiplier
  typedef struct packed {
    logic              valid;
    shift_sel_e        shift;
    logic signed [32:0] a;
    logic signed [24:0] b;
  } mul_req_t;

  // Saturate a 33-bit sum to signed 32 bits
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/uhr_mul_unit.sv @@
// Shared two-stage multiplier with round-to-nearest, shift and saturation.
// Depends on uhr_pkg for the request type and shift selector.
`timescale 1ns / 1ps

module uhr_mul_unit (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  uhr_pkg::mul_req_t       req_i,
  output logic                    valid_o,
  output logic signed [31:0]      result_o
);

  logic signed [57:0]   prod_q;
  logic signed [57:0]   prod_d;
  uhr_pkg::shift_sel_e  shift_q;
  logic                 vld1_q;
  logic                 vld2_q;
  logic signed [31:0]   res_q;
  logic signed [31:0]   res_d;
  logic signed [58:0]   rnd_sum;
  logic signed [58:0]   shifted;

  // Stage 1: signed product
  assign prod_d = req_i.a * req_i.b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= req_i.valid;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    shift_q <= req_i.shift;
    res_q   <= res_d;
  end

  // Stage 2: add half an LSB, floor shift, saturate
  always_comb begin
    rnd_sum = 59'sd0;
    shifted = 59'sd0;
    case (shift_q)
      uhr_pkg::SHIFT_8: begin
        rnd_sum = {prod_q[57], prod_q} + 59'sd128;
        shifted = rnd_sum >>> 8;
      end
      uhr_pkg::SHIFT_15: begin
        rnd_sum = {prod_q[57], prod_q} + 59'sd16384;
        shifted = rnd_sum >>> 15;
      end
      uhr_pkg::SHIFT_16: begin
        rnd_sum = {prod_q[57], prod_q} + 59'sd32768;
        shifted = rnd_sum >>> 16;
      end
      default: begin
        rnd_sum = 59'sd0;
        shifted = 59'sd0;
      end
    endcase
    if (shifted > 59'sh7fff_ffff) begin
      res_d = 32'sh7fff_ffff;
    end else if (shifted < -59'sh8000_0000) begin
      res_d = 32'sh8000_0000;
    end else begin
      res_d = shifted[31:0];
    end
  end

  assign valid_o  = vld2_q;
  assign result_o = res_q;

endmodule

@@ rtl/unit_hydrograph_routing_step_core.sv @@
// Top level of the unit hydrograph routing step: sequencer, tap and ordinate
// memories, configuration registers. Depends on uhr_pkg and uhr_mul_unit.
`timescale 1ns / 1ps

// Usage:
//   s_axis carries load items (write one ordinate) and flow samples. m_axis
//   returns one result per item: outflow, stored volume and a status flag.
//   cfg_* writes a configuration register; it is always ready. The user
//   must write while the block is idle; the block itself has no check.
// Processing:
//   A load item or a missing sample goes from accept to the hand-over step
//   and then into the output register. A flow sample makes one pass of the
//   shared multiplier per active tap unless bypassed, plus the products for
//   the lateral term and the volume update through the same two-stage unit.
//   One item is in work at a time; s_axis_tready is high only when idle.
// Reset:
//   After reset a clearing pass zeroes the tap memory, one entry a cycle,
//   through all MAX_TAPS entries; no item is accepted meanwhile.
// Stalls:
//   A result sits in the output register until taken; a finished item waits
//   in the hand-over step for the register to free up, and the next item
//   can be accepted once the sequencer has handed its result over.
module unit_hydrograph_routing_step_core #(
  parameter int unsigned MAX_TAPS = uhr_pkg::MaxTapsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // coef_index[5:0], coef_value[21:6], inflow[53:22], pad
  input  logic [1:0]  s_axis_tuser,  // func[0], inflow_missing[1]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // outflow[31:0], stored_volume[63:32]
  output logic        m_axis_tuser,  // status[0]
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int unsigned CW = $clog2(MAX_TAPS + 1);

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CUM   = 4'd2;
  localparam logic [3:0] ST_DEC   = 4'd3;
  localparam logic [3:0] ST_PHI   = 4'd4;
  localparam logic [3:0] ST_TAPS  = 4'd5;
  localparam logic [3:0] ST_OUTF  = 4'd6;
  localparam logic [3:0] ST_DVI   = 4'd7;
  localparam logic [3:0] ST_DV    = 4'd8;
  localparam logic [3:0] ST_SC    = 4'd9;
  localparam logic [3:0] ST_OUT   = 4'd10;

  // Input fields
  logic [5:0]         in_coef_index;
  logic [15:0]        in_coef_value;
  logic signed [31:0] in_inflow;
  logic               in_func;
  logic               in_missing;

  assign in_coef_index = s_axis_tdata[5:0];
  assign in_coef_value = s_axis_tdata[21:6];
  assign in_inflow     = s_axis_tdata[53:22];
  assign in_func       = s_axis_tuser[0];
  assign in_missing    = s_axis_tuser[1];

  // Configuration registers
  logic [6:0]  tap_count_q;
  logic        lateral_q;
  logic [15:0] step_length_q;
  logic [23:0] step_over_delay_q;
  logic [15:0] margin_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q       <= uhr_pkg::TapCountRst;
      lateral_q         <= 1'b0;
      step_length_q     <= uhr_pkg::StepLengthRst;
      step_over_delay_q <= uhr_pkg::StepOverDelayRst;
      margin_q          <= uhr_pkg::ShortcutMarginRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        uhr_pkg::CFG_TAP_COUNT:       tap_count_q       <= cfg_data_i[6:0];
        uhr_pkg::CFG_LATERAL_MODE:    lateral_q         <= cfg_data_i[0];
        uhr_pkg::CFG_STEP_LENGTH:     step_length_q     <= cfg_data_i[15:0];
        uhr_pkg::CFG_STEP_OVER_DELAY: step_over_delay_q <= cfg_data_i[23:0];
        uhr_pkg::CFG_SHORTCUT_MARGIN: margin_q          <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Effective tap count, clamped to 1..MAX_TAPS
  logic [CW-1:0] n_eff;
  logic [AW-1:0] n_last;

  always_comb begin
    if (tap_count_q == 7'd0) begin
      n_eff = CW'(1);
    end else if (32'(tap_count_q) > 32'(MAX_TAPS)) begin
      n_eff = CW'(MAX_TAPS);
    end else begin
      n_eff = CW'(tap_count_q);
    end
    n_last = AW'(n_eff - CW'(1));
  end

  // Sequencer state and datapath registers
  logic [3:0]         state_q, state_d;
  logic [AW-1:0]      k_q, k_d;
  logic               issuing_q, issuing_d;
  logic signed [31:0] qin_q, qin_d;
  logic signed [31:0] qcum_q, qcum_d;
  logic signed [31:0] cum_q, cum_d;
  logic signed [31:0] transit_q, transit_d;
  logic signed [31:0] phi_q, phi_d;
  logic signed [31:0] qconv_q, qconv_d;
  logic signed [31:0] tap0_q, tap0_d;
  logic signed [31:0] outflow_q, outflow_d;
  logic signed [31:0] res_outflow_q, res_outflow_d;
  logic               res_status_q, res_status_d;

  // Tap pipeline alongside the multiplier
  logic               s1_vld_q, s2_vld_q, s3_vld_q;
  logic               s1_last_q, s2_last_q, s3_last_q;
  logic [AW-1:0]      s1_k_q, s2_k_q, s3_k_q;
  logic signed [31:0] s2_tap_q, s3_tap_q;

  // Output register
  logic               out_valid_q;
  logic signed [31:0] out_outflow_q;
  logic signed [31:0] out_volume_q;
  logic               out_status_q;
  logic               out_load;

  // Memories
  logic [15:0]        coef_mem [MAX_TAPS];
  logic signed [31:0] tap_mem  [MAX_TAPS];
  logic [15:0]        coef_rd_q;
  logic signed [31:0] tap_rd_q;
  logic               coef_we;
  logic [AW-1:0]      coef_waddr;
  logic               tap_we;
  logic [AW-1:0]      tap_waddr;
  logic signed [31:0] tap_wdata;
  logic [AW-1:0]      tap_raddr;

  // Shared multiplier
  uhr_pkg::mul_req_t  mul_req;
  logic               mul_vld;
  logic signed [31:0] mul_res;

  uhr_mul_unit u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (mul_req),
    .valid_o  (mul_vld),
    .result_o (mul_res)
  );

  logic               in_accept;
  logic               shortcut;
  logic signed [17:0] threshold;
  logic signed [31:0] tap_sum;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  // Ordinate zero above one minus margin bypasses the taps
  assign threshold = 18'sd32768 - $signed({2'b00, margin_q});
  assign shortcut  = $signed({2'b00, coef_rd_q}) > threshold;

  // Sum written back to a tap; the last tap takes the product alone
  assign tap_sum = s3_last_q ? mul_res : uhr_pkg::sat33(33'(s3_tap_q) + 33'(mul_res));

  // Ordinate memory: written by load items, read at the issue index
  assign coef_we    = in_accept && (in_func == uhr_pkg::FUNC_LOAD) &&
                      (32'(in_coef_index) < 32'(MAX_TAPS));
  assign coef_waddr = AW'(in_coef_index);
  assign tap_raddr  = k_q + AW'(1);

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= in_coef_value;
    end
    coef_rd_q <= coef_mem[k_q];
  end

  always_ff @(posedge clk_i) begin
    if (tap_we) begin
      tap_mem[tap_waddr] <= tap_wdata;
    end
    tap_rd_q <= tap_mem[tap_raddr];
  end

  // Tap memory write port: clearing pass, shortcut, or convolution
  always_comb begin
    tap_we    = 1'b0;
    tap_waddr = k_q;
    tap_wdata = 32'sd0;
    case (state_q)
      ST_CLEAR: begin
        tap_we = 1'b1;
      end
      ST_SC: begin
        tap_we    = 1'b1;
        tap_wdata = (k_q == AW'(0)) ? qin_q : 32'sd0;
      end
      ST_TAPS: begin
        tap_we    = s3_vld_q && mul_vld;
        tap_waddr = s3_k_q;
        tap_wdata = tap_sum;
      end
      default: ;
    endcase
  end

  // Multiplier request by sequencer step
  always_comb begin
    mul_req.valid = 1'b0;
    mul_req.shift = uhr_pkg::SHIFT_15;
    mul_req.a     = 33'(qconv_q);
    mul_req.b     = $signed({9'd0, coef_rd_q});
    case (state_q)
      ST_DEC: begin
        mul_req.valid = !shortcut;
        mul_req.shift = uhr_pkg::SHIFT_16;
        mul_req.a     = 33'(qcum_q);
        mul_req.b     = $signed({1'b0, step_over_delay_q});
      end
      ST_TAPS: begin
        mul_req.valid = s1_vld_q;
      end
      ST_DVI: begin
        mul_req.valid = 1'b1;
        mul_req.shift = uhr_pkg::SHIFT_8;
        mul_req.a     = 33'(qin_q) - 33'(outflow_q);
        mul_req.b     = $signed({9'd0, step_length_q});
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d       = state_q;
    k_d           = k_q;
    issuing_d     = issuing_q;
    qin_d         = qin_q;
    qcum_d        = qcum_q;
    cum_d         = cum_q;
    transit_d     = transit_q;
    phi_d         = phi_q;
    qconv_d       = qconv_q;
    tap0_d        = tap0_q;
    outflow_d     = outflow_q;
    res_outflow_d = res_outflow_q;
    res_status_d  = res_status_q;
    case (state_q)
      ST_CLEAR: begin
        if (k_q == AW'(MAX_TAPS - 1)) begin
          k_d     = '0;
          state_d = ST_IDLE;
        end else begin
          k_d = k_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          qin_d         = in_inflow[31] ? 32'sd0 : in_inflow;
          res_outflow_d = 32'sd0;
          res_status_d  = uhr_pkg::STATUS_OK;
          if (in_func == uhr_pkg::FUNC_LOAD) begin
            state_d = ST_OUT;
          end else if (in_missing) begin
            res_status_d = uhr_pkg::STATUS_MISSING;
            state_d      = ST_OUT;
          end else begin
            state_d = ST_CUM;
          end
        end
      end
      ST_CUM: begin
        // ordinate zero is read at this edge
        qcum_d  = uhr_pkg::sat33(33'(cum_q) + 33'(qin_q));
        state_d = ST_DEC;
      end
      ST_DEC: begin
        k_d     = '0;
        state_d = shortcut ? ST_SC : ST_PHI;
      end
      ST_PHI: begin
        if (mul_vld) begin
          phi_d = mul_res;
          if (lateral_q) begin
            qconv_d = uhr_pkg::sat33(-33'(mul_res));
          end else begin
            qconv_d = qin_q;
          end
          k_d       = '0;
          issuing_d = 1'b1;
          state_d   = ST_TAPS;
        end
      end
      ST_TAPS: begin
        if (issuing_q) begin
          if (k_q == n_last) begin
            issuing_d = 1'b0;
          end else begin
            k_d = k_q + AW'(1);
          end
        end
        if (s3_vld_q && mul_vld) begin
          if (s3_k_q == AW'(0)) begin
            tap0_d = tap_sum;
          end
          if (s3_last_q) begin
            k_d     = '0;
            state_d = ST_OUTF;
          end
        end
      end
      ST_OUTF: begin
        outflow_d = lateral_q ? uhr_pkg::sat33(33'(tap0_q) + 33'(phi_q)) : tap0_q;
        state_d   = ST_DVI;
      end
      ST_DVI: begin
        state_d = ST_DV;
      end
      ST_DV: begin
        if (mul_vld) begin
          transit_d     = uhr_pkg::sat33(33'(transit_q) + 33'(mul_res));
          cum_d         = qcum_q;
          res_outflow_d = outflow_q;
          res_status_d  = uhr_pkg::STATUS_OK;
          state_d       = ST_OUT;
        end
      end
      ST_SC: begin
        if (k_q == n_last) begin
          k_d       = '0;
          outflow_d = qin_q;
          state_d   = ST_DVI;
        end else begin
          k_d = k_q + AW'(1);
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      k_q       <= '0;
      issuing_q <= 1'b0;
      cum_q     <= 32'sd0;
      transit_q <= 32'sd0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      k_q       <= k_d;
      issuing_q <= issuing_d;
      cum_q     <= cum_d;
      transit_q <= transit_d;
      s1_vld_q  <= (state_q == ST_TAPS) && issuing_q;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    qin_q         <= qin_d;
    qcum_q        <= qcum_d;
    phi_q         <= phi_d;
    qconv_q       <= qconv_d;
    tap0_q        <= tap0_d;
    outflow_q     <= outflow_d;
    res_outflow_q <= res_outflow_d;
    res_status_q  <= res_status_d;
    s1_k_q        <= k_q;
    s1_last_q     <= (k_q == n_last);
    s2_k_q        <= s1_k_q;
    s2_last_q     <= s1_last_q;
    s2_tap_q      <= tap_rd_q;
    s3_k_q        <= s2_k_q;
    s3_last_q     <= s2_last_q;
    s3_tap_q      <= s2_tap_q;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_outflow_q <= res_outflow_q;
      out_volume_q  <= transit_q;
      out_status_q  <= res_status_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_volume_q, out_outflow_q};
  assign m_axis_tuser  = out_status_q;

`ifndef ASSERT_OFF
  // No item is taken during the clearing pass
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !s_axis_tready)
    else $error("input accepted during tap clearing pass");

  // Multiplier results only arrive where the sequencer waits for them
  a_mul_vld_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_vld |-> (state_q == ST_PHI || state_q == ST_TAPS || state_q == ST_DV))
    else $error("multiplier result in unexpected state");

  // A new result only comes from the hand-over step
  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_OUT)
    else $error("result loaded outside hand-over step");

  // Tap pipeline stays aligned with the multiplier
  a_tap_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAPS && s3_vld_q) |-> mul_vld)
    else $error("tap pipeline out of step with multiplier");
`endif

endmodule

@@ bench/tb_unit_hydrograph_routing_step_core.sv @@
// Self-checking bench for unit_hydrograph_routing_step_core: directed table, then random
// phases over several register settings, checked against an in-bench routing predictor.
// Depends on uhr_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_unit_hydrograph_routing_step_core;
  import uhr_pkg::*;

  localparam int NUM_TAPS    = 64;
  localparam int DIR_ROWS    = 19;
  localparam int NUM_PHASES  = 8;
  localparam int TAIL_CYCLES = 100;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER  = 120;
  localparam int CYCLE_LIMIT = 500000;

  // One input transaction
  typedef struct packed {
    logic               func;
    logic [5:0]         idx;
    logic [15:0]        cval;
    logic signed [31:0] inflow;
    logic               missing;
  } uh_item_t;

  // One result transaction
  typedef struct packed {
    logic signed [31:0] outflow;
    logic signed [31:0] volume;
    logic               status;
  } uh_result_t;

  // Directed row; typed marks a hand-written expectation
  typedef struct packed {
    logic               func;
    logic [5:0]         idx;
    logic [15:0]        cval;
    logic signed [31:0] inflow;
    logic               missing;
    logic               typed;
    logic signed [31:0] exp_out;
    logic signed [31:0] exp_vol;
    logic               exp_status;
  } dir_row_t;

  // Register setting and item count of one random phase
  typedef struct packed {
    logic [6:0]  taps;
    logic        lat;
    logic [15:0] slen;
    logic [23:0] sod;
    logic [15:0] margin;
    logic [15:0] items;
    logic        big;
  } phase_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;   // coef_index, coef_value, inflow, pad
  logic [1:0]  s_axis_tuser;   // func, inflow_missing
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // outflow, stored_volume
  logic        m_axis_tuser;   // status
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [23:0] cfg_data_i;

  unit_hydrograph_routing_step_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor state and register shadow
  logic [15:0]        ord_mem  [NUM_TAPS];
  logic signed [31:0] tap_mem  [NUM_TAPS];
  logic signed [31:0] cum_inflow;
  logic signed [31:0] transit_vol;
  logic [6:0]         cfg_taps;
  logic               cfg_lateral;
  logic [15:0]        cfg_step_len;
  logic [23:0]        cfg_sod;
  logic [15:0]        cfg_margin;

  uh_result_t expected_routing_q[$];
  uh_result_t want;
  int n_fail       = 0;
  int results_seen = 0;
  int burst_left   = 0;
  int cyc          = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;
  int rx_mode;
  int rx_seg;

  // Extremes at the head, special cases in the middle
  dir_row_t dir_tbl [DIR_ROWS] = '{
    // missing sample right after reset: nothing stored yet
    '{FUNC_FLOW, 6'd0,  16'd0,     32'sh7fff_ffff, 1'b1, 1'b1, 32'sd0, 32'sd0, STATUS_MISSING},
    '{FUNC_LOAD, 6'd0,  16'd0,     32'sh0000_0000, 1'b0, 1'b1, 32'sd0, 32'sd0, STATUS_OK},
    // most negative inflow clamps to zero, zero ordinate: nothing moves
    '{FUNC_FLOW, 6'd0,  16'd0,     32'sh8000_0000, 1'b0, 1'b1, 32'sd0, 32'sd0, STATUS_OK},
    // top index, full ordinate; missing flag ignored on a load
    '{FUNC_LOAD, 6'd63, 16'd32768, 32'shffff_ffff, 1'b1, 1'b1, 32'sd0, 32'sd0, STATUS_OK},
    '{FUNC_FLOW, 6'd0,  16'd0,     32'sh0001_0000, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
    '{FUNC_LOAD, 6'd0,  16'd32768, 32'sh0000_0000, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
    // first ordinate at one: bypass
    '{FUNC_FLOW, 6'd0,  16'd0,     32'sh0002_8000, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
    '{FUNC_FLOW, 6'd0,  16'd0,     32'sh5555_5555, 1'b1, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
    '{FUNC_FLOW, 6'd0,  16'd0,     32'shaaaa_aaaa, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
    // ordinate exactly at one minus margin still convolves
    '{FUNC_LOAD, 6'd0,  16'd32735, 32'sh0000_0000, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
    '{FUNC_FLOW, 6'd0,  16'd0,     32'sh0001_8000, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
    // one LSB above the threshold bypasses
    '{FUNC_LOAD, 6'd0,  16'd32736, 32'sh0000_0000, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
    '{FUNC_FLOW, 6'd0,  16'd0,     32'sh0000_0001, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
    '{FUNC_LOAD, 6'd21, 16'h7fff,  32'sh0000_0000, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
    '{FUNC_LOAD, 6'd42, 16'h5555,  32'sh0000_0000, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
    '{FUNC_LOAD, 6'd0,  16'd16384, 32'sh0000_0000, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
    '{FUNC_FLOW, 6'd0,  16'd0,     32'sh0003_0000, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
    '{FUNC_FLOW, 6'd0,  16'd0,     32'sh0000_ffff, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK},
    '{FUNC_FLOW, 6'd0,  16'd0,     32'shffff_ffff, 1'b0, 1'b0, 32'sd0, 32'sd0, STATUS_OK}
  };

  // taps, lateral, step length, step/delay, margin, items, large inflows
  phase_t phase_tbl [NUM_PHASES] = '{
    '{7'd64,  1'b0, 16'd256,   24'd65536,    16'd0,     16'd50, 1'b0},
    '{7'd8,   1'b1, 16'd128,   24'd6554,     16'd33,    16'd50, 1'b0},
    // tap count zero acts as one; margin of one bypasses any nonzero ordinate
    '{7'd0,   1'b0, 16'd65535, 24'd0,        16'd32768, 16'd30, 1'b0},
    // tap count above the maximum; margin above one always bypasses
    '{7'd127, 1'b1, 16'd0,     24'd16777215, 16'd65535, 16'd30, 1'b0},
    '{7'd5,   1'b1, 16'd300,   24'd32768,    16'd1000,  16'd40, 1'b0},
    // stale upper taps from the short phase come back into use
    '{7'd40,  1'b0, 16'd256,   24'd65536,    16'd33,    16'd40, 1'b1},
    '{7'd64,  1'b1, 16'd700,   24'd100000,   16'd500,   16'd40, 1'b1},
    '{7'd1,   1'b0, 16'd65535, 24'd16777215, 16'd0,     16'd30, 1'b1}
  };

  // Clock, 2 ns period
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Run limit
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > longint'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
    if (v < -longint'(32'sh7fff_ffff) - 1) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Round to nearest (ties up) after dropping s fraction bits, then saturate
  function automatic logic signed [31:0] rnd_shift(input longint v, input int s);
    return sat32((v + (longint'(1) << (s - 1))) >>> s);
  endfunction

  // Routing step: updates predictor state, returns the expected result
  function automatic uh_result_t route_sample(input uh_item_t it);
    uh_result_t r;
    logic signed [31:0] qin, qcum, phi, qconv, prod, outq, dv;
    int n, c0, thr;
    r.outflow = '0;
    r.volume  = transit_vol;
    r.status  = STATUS_OK;
    if (it.func == FUNC_LOAD) begin
      ord_mem[it.idx] = it.cval;
      return r;
    end
    if (it.missing) begin
      r.status = STATUS_MISSING;
      return r;
    end
    qin  = (it.inflow < 0) ? 32'sd0 : it.inflow;
    qcum = sat32(longint'(cum_inflow) + longint'(qin));
    n = cfg_taps;
    if (n == 0) n = 1;
    if (n > NUM_TAPS) n = NUM_TAPS;
    c0  = ord_mem[0];
    thr = 32768 - int'(cfg_margin);
    if (c0 > thr) begin
      // bypass: pass-through, active taps clear
      tap_mem[0] = qin;
      for (int k = 1; k < n; k++) tap_mem[k] = '0;
      outq = qin;
    end else begin
      phi   = rnd_shift(longint'(qcum) * longint'(cfg_sod), 16);
      qconv = cfg_lateral ? sat32(-longint'(phi)) : qin;
      for (int k = 0; k + 1 < n; k++) begin
        prod       = rnd_shift(longint'(ord_mem[k]) * longint'(qconv), 15);
        tap_mem[k] = sat32(longint'(tap_mem[k + 1]) + longint'(prod));
      end
      tap_mem[n - 1] = rnd_shift(longint'(ord_mem[n - 1]) * longint'(qconv), 15);
      outq = cfg_lateral ? sat32(longint'(tap_mem[0]) + longint'(phi)) : tap_mem[0];
    end
    dv = rnd_shift((longint'(qin) - longint'(outq)) * longint'(cfg_step_len), 8);
    transit_vol = sat32(longint'(transit_vol) + longint'(dv));
    cum_inflow  = qcum;
    r.outflow = outq;
    r.volume  = transit_vol;
    return r;
  endfunction

  // Offer one transaction in bursts with random gaps; called at a falling edge
  task automatic send_item(input uh_item_t it, input bit typed, input uh_result_t typed_res);
    uh_result_t r;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.inflow, it.cval, it.idx};
    s_axis_tuser  <= {it.missing, it.func};
    do @(posedge clk_i); while (!s_axis_tready);
    r = route_sample(it);
    if (typed) r = typed_res;
    expected_routing_q.push_back(r);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TAP_COUNT:       cfg_taps     = data[6:0];
      CFG_LATERAL_MODE:    cfg_lateral  = data[0];
      CFG_STEP_LENGTH:     cfg_step_len = data[15:0];
      CFG_STEP_OVER_DELAY: cfg_sod      = data[23:0];
      CFG_SHORTCUT_MARGIN: cfg_margin   = data[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stop offering and wait for every pending result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_routing_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Random transaction; big enables full-range inflow
  function automatic uh_item_t rand_item(input bit big);
    uh_item_t it;
    int sel, b;
    sel        = $urandom_range(0, 99);
    it.idx     = $urandom_range(0, 63);
    it.cval    = $urandom_range(0, 32768);
    it.inflow  = $urandom;
    it.missing = 1'b0;
    if (sel < 15) begin
      it.func    = FUNC_LOAD;
      it.missing = $urandom_range(0, 1);
      if ($urandom_range(0, 2) == 0) it.idx = 6'd0;
      case ($urandom_range(0, 3))
        0: it.cval = 16'd32768;
        1: begin
          // straddle the bypass threshold
          b = 32768 - int'(cfg_margin) + int'($urandom_range(0, 1));
          if (b < 0) b = 0;
          if (b > 32768) b = 32768;
          it.cval = b;
        end
        2: it.cval = $urandom_range(0, 4096);
        default: ;
      endcase
    end else if (sel < 23) begin
      it.func    = FUNC_FLOW;
      it.missing = 1'b1;
    end else begin
      it.func = FUNC_FLOW;
      if (!(big && $urandom_range(0, 3) == 0)) begin
        if ($urandom_range(0, 5) == 0) it.inflow = -$signed($urandom_range(1, 32'h0010_0000));
        else it.inflow = $urandom_range(0, 32'h0004_0000);
      end
    end
    return it;
  endfunction

  // Result check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_routing_q.size() == 0) begin
        $error("result transaction with nothing expected: tdata %h", m_axis_tdata);
        n_fail++;
      end else begin
        want = expected_routing_q.pop_front();
        if (m_axis_tdata[31:0] !== want.outflow) begin
          $error("outflow: expected %0d, got %0d", want.outflow, $signed(m_axis_tdata[31:0]));
          n_fail++;
        end
        if (m_axis_tdata[63:32] !== want.volume) begin
          $error("stored_volume: expected %0d, got %0d", want.volume,
                 $signed(m_axis_tdata[63:32]));
          n_fail++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          n_fail++;
        end
      end
    end
  end

  // Receiver: stall segments of mixed density, plus one long hold-off
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      rx_mode = $urandom_range(0, 2);
      rx_seg  = $urandom_range(20, 80);
      repeat (rx_seg) begin
        @(negedge clk_i);
        if (!hold_done && results_seen >= HOLD_AFTER) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          m_axis_tready <= 1'b0;
        end else begin
          case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  // Main sequence
  initial begin
    uh_item_t   it;
    uh_result_t tres;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_TAP_COUNT;
    cfg_data_i    = '0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      ord_mem[k] = '0;
      tap_mem[k] = '0;
    end
    cum_inflow   = '0;
    transit_vol  = '0;
    cfg_taps     = TapCountRst;
    cfg_lateral  = 1'b0;
    cfg_step_len = StepLengthRst;
    cfg_sod      = StepOverDelayRst;
    cfg_margin   = ShortcutMarginRst;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table under reset settings
    for (int i = 0; i < DIR_ROWS; i++) begin
      it.func       = dir_tbl[i].func;
      it.idx        = dir_tbl[i].idx;
      it.cval       = dir_tbl[i].cval;
      it.inflow     = dir_tbl[i].inflow;
      it.missing    = dir_tbl[i].missing;
      tres.outflow  = dir_tbl[i].exp_out;
      tres.volume   = dir_tbl[i].exp_vol;
      tres.status   = dir_tbl[i].exp_status;
      send_item(it, dir_tbl[i].typed, tres);
    end

    // Fill every ordinate so no later read hits an unwritten entry
    for (int k = 0; k < NUM_TAPS; k++) begin
      it.func    = FUNC_LOAD;
      it.idx     = k;
      it.cval    = ($urandom_range(0, 3) == 0) ? 16'd32768 : 16'($urandom_range(0, 32768));
      it.inflow  = $urandom;
      it.missing = $urandom_range(0, 1);
      send_item(it, 1'b0, tres);
    end

    // Random phases, registers rewritten while idle
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(CFG_TAP_COUNT,       24'(phase_tbl[p].taps));
      write_reg(CFG_LATERAL_MODE,    24'(phase_tbl[p].lat));
      write_reg(CFG_STEP_LENGTH,     24'(phase_tbl[p].slen));
      write_reg(CFG_STEP_OVER_DELAY, phase_tbl[p].sod);
      write_reg(CFG_SHORTCUT_MARGIN, 24'(phase_tbl[p].margin));
      for (int i = 0; i < int'(phase_tbl[p].items); i++) begin
        send_item(rand_item(phase_tbl[p].big), 1'b0, tres);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (n_fail == 0 && expected_routing_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
